// ===== design/bsst_pkg.sv =====
package bsst_pkg;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 11;
  localparam int HELD_W  = 11;

  // default store depth and capacity after reset
  localparam int         BSST_DEPTH = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET  = 11'd1024;

endpackage

// ===== design/bsst_item_if.sv =====
interface bsst_item_if
  import bsst_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== design/bsst_result_if.sv =====
interface bsst_result_if
  import bsst_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               status;
  logic [HELD_W-1:0]  held_count;
  logic [VALUE_W-1:0] shortest_span;
  logic [VALUE_W-1:0] longest_span;
  logic               spans_valid;

  modport source (output valid, output status, output held_count, output shortest_span,
                  output longest_span, output spans_valid, input ready);
  modport sink   (input valid, input status, input held_count, input shortest_span,
                  input longest_span, input spans_valid, output ready);
endinterface

// ===== design/bounded_set_span_tracker.sv =====
// flow: a stored word is accepted, compared against every held value in a scan, then
//   finished; a refused word or the first word skips the scan; one compare per held
//   value on the single read port, and the block takes no new word while scanning
// reset: synchronous, active high; clears count, min, max, best gap to all ones and
//   capacity to 1024; store contents stay undefined and need no clearing pass
module bounded_set_span_tracker
  import bsst_pkg::*;
#(
  parameter int DEPTH = BSST_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               capacity_we,
  input  logic [CAP_W-1:0]   capacity_wdata,
  bsst_item_if.sink          item,
  bsst_result_if.source      result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // store address
  localparam int CW = $clog2(DEPTH + 1);                 // count, holds DEPTH itself
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;         // width for the capacity compare

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t             state;
  logic [CAP_W-1:0]   capacity;
  logic [CW-1:0]      count;
  logic [VALUE_W-1:0] smallest_value;
  logic [VALUE_W-1:0] largest_value;
  logic [VALUE_W-1:0] best_gap;

  // word under work
  logic [VALUE_W-1:0] cur_value;
  logic               refused;

  // scan sequencer: address issued this cycle, compare valid for last cycle's read
  logic [CW-1:0]      scan_addr;
  logic               cmp_valid;

  // value store, one write and one registered read port
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic               out_valid;
  logic               out_status;
  logic [HELD_W-1:0]  out_held;
  logic [VALUE_W-1:0] out_shortest;
  logic [VALUE_W-1:0] out_longest;
  logic               out_spans_valid;

  logic               item_take;
  logic               full;
  logic [LW-1:0]      cap_ext;
  logic [LW-1:0]      depth_ext;
  logic [LW-1:0]      limit;
  logic               mem_we;

  // distance unit: |cur_value - rdata| with signed ordering
  logic               ge;
  logic [VALUE_W-1:0] gap_diff;

  logic [CW-1:0]      count_next;
  logic               can_load;

  assign item.ready = (state == ST_IDLE);
  assign item_take  = item.valid && item.ready;

  // effective limit is capacity saturated at the store depth
  assign cap_ext   = LW'(capacity);
  assign depth_ext = LW'(DEPTH);
  assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign full      = (LW'(count) >= limit);
  assign mem_we    = item_take && !full;

  assign ge       = ($signed(cur_value) >= $signed(rdata));
  assign gap_diff = ge ? (cur_value - rdata) : (rdata - cur_value);

  assign count_next = refused ? count : (count + CW'(1));
  // output register frees up as the result word is taken
  assign can_load   = !out_valid || result.ready;

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.held_count    = out_held;
  assign result.shortest_span = out_shortest;
  assign result.longest_span  = out_longest;
  assign result.spans_valid   = out_spans_valid;

  // store: new word goes in at the current count, scan compares only below it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= item.value;
    end
    rdata <= mem[scan_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      capacity        <= CAP_RESET;
      count           <= '0;
      smallest_value  <= '0;
      largest_value   <= '0;
      best_gap        <= '1;
      refused         <= 1'b0;
      scan_addr       <= '0;
      cmp_valid       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_wdata;
      end
      // in finish the load below decides the output valid
      if (out_valid && result.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_take) begin
            cur_value <= item.value;
            scan_addr <= '0;
            cmp_valid <= 1'b0;
            if (full) begin
              refused <= 1'b1;
              state   <= ST_FINISH;
            end else begin
              refused <= 1'b0;
              // running min and max fold in at accept
              if (count == '0) begin
                smallest_value <= item.value;
                largest_value  <= item.value;
                state          <= ST_FINISH;
              end else begin
                if ($signed(item.value) < $signed(smallest_value)) begin
                  smallest_value <= item.value;
                end
                if ($signed(item.value) > $signed(largest_value)) begin
                  largest_value <= item.value;
                end
                state <= ST_SCAN;
              end
            end
          end
        end

        ST_SCAN: begin
          // issue one read a cycle, compare it in the next cycle
          if (scan_addr < count) begin
            scan_addr <= scan_addr + CW'(1);
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid && (gap_diff < best_gap)) begin
            best_gap <= gap_diff;
          end
          if ((scan_addr == count) && !cmp_valid) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            out_status <= refused;
            out_held   <= HELD_W'(count_next);
            if (count_next >= CW'(2)) begin
              out_shortest    <= best_gap;
              // largest is never below smallest, so the modular difference is exact
              out_longest     <= largest_value - smallest_value;
              out_spans_valid <= 1'b1;
            end else begin
              out_shortest    <= '0;
              out_longest     <= '0;
              out_spans_valid <= 1'b0;
            end
            count <= count_next;
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= depth_ext)
    else $error("count above store depth");

  a_gap_monotone: assert property (@(posedge clk) disable iff (rst)
    1 |=> (best_gap <= $past(best_gap)))
    else $error("best gap grew");

  a_min_max_order: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> ($signed(largest_value) >= $signed(smallest_value)))
    else $error("largest below smallest");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (count != '0))
    else $error("scan with empty store");
`endif

endmodule

// ===== tb/span_book_pkg.sv =====
package span_book_pkg;
  import bsst_pkg::*;

  // one result word as seen on the result channel
  typedef struct packed {
    logic               status;
    logic [HELD_W-1:0]  held_count;
    logic [VALUE_W-1:0] shortest_span;
    logic [VALUE_W-1:0] longest_span;
    logic               spans_valid;
  } span_word_t;

  class span_book;
    logic [VALUE_W-1:0] held[$];
    logic [VALUE_W-1:0] low_val;
    logic [VALUE_W-1:0] high_val;
    logic [VALUE_W-1:0] best_gap;
    logic [CAP_W-1:0]   capacity;
    span_word_t         pending[$];
    int                 errors;

    function new();
      low_val  = '0;
      high_val = '0;
      best_gap = '1;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    // exact unsigned distance between two signed values
    function logic [VALUE_W-1:0] gap_of(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
      return ($signed(a) >= $signed(b)) ? a - b : b - a;
    endfunction

    function void note_offer(logic [VALUE_W-1:0] v);
      int unsigned        limit;
      logic [VALUE_W-1:0] d;
      span_word_t         w;
      limit = (capacity > BSST_DEPTH) ? BSST_DEPTH : capacity;
      w = '0;
      if (held.size() >= limit) begin
        w.status = 1'b1;
      end else begin
        foreach (held[i]) begin
          d = gap_of(v, held[i]);
          if (d < best_gap) best_gap = d;
        end
        if (held.size() == 0) begin
          low_val  = v;
          high_val = v;
        end else begin
          if ($signed(v) < $signed(low_val)) low_val = v;
          if ($signed(v) > $signed(high_val)) high_val = v;
        end
        held = {held, v};
      end
      w.held_count = HELD_W'(held.size());
      if (held.size() >= 2) begin
        w.shortest_span = best_gap;
        w.longest_span  = gap_of(high_val, low_val);
        w.spans_valid   = 1'b1;
      end
      pending = {pending, w};
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(span_word_t got);
      span_word_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: expected none, actual %0h",
                 $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("held_count", want.held_count, got.held_count);
      compare_field("shortest_span", want.shortest_span, got.shortest_span);
      compare_field("longest_span", want.longest_span, got.longest_span);
      compare_field("spans_valid", want.spans_valid, got.spans_valid);
    endfunction

    function void report_leftover();
      if (pending.size() != 0) begin
        errors += pending.size();
        $display("%0t: %0d expected result words never arrived", $time, pending.size());
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_bounded_set_span_tracker.sv =====
module tb_bounded_set_span_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import bsst_pkg::*;
  import span_book_pkg::*;

  // run sizing
  localparam int RANDOM_WORDS = 560;
  localparam int LONG_HOLD    = 500;          // receiver back-pressure stretch
  localparam int SETTLE       = BSST_DEPTH + 8; // longest scan plus margin
  // watchdog limit, well above the slowest run even with every stall maxed out
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic             clk;
  logic             rst;
  logic             capacity_we;
  logic [CAP_W-1:0] capacity_wdata;

  bsst_item_if   item_ch();
  bsst_result_if result_ch();

  bounded_set_span_tracker uut (
    .clk            (clk),
    .rst            (rst),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .item           (item_ch),
    .result         (result_ch)
  );

  span_book    book;
  span_word_t  seen;
  int unsigned cycle_count = 0;

  // sender side idling, owned by the main process
  bit tx_idle_on = 1'b1;
  // receiver side controls; the main process writes rx_idle_on and hold_asks with nonblocking updates
  bit rx_idle_on = 1'b1;
  int hold_asks  = 0;
  int holds_done = 0;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on a hung handshake or a missing result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold when the main process asks for one
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (holds_done != hold_asks) begin
        // long hold: block fills with one pending result and stops taking words
        holds_done++;
        stall_left = LONG_HOLD - 1;
        result_ch.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor: sample at the edge, compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen.status        = result_ch.status;
      seen.held_count    = result_ch.held_count;
      seen.shortest_span = result_ch.shortest_span;
      seen.longest_span  = result_ch.longest_span;
      seen.spans_valid   = result_ch.spans_valid;
      book.check_result(seen);
    end
  end

  // offer one word, hold it until taken, then maybe go quiet for a burst
  task automatic send_word(input logic [VALUE_W-1:0] v);
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    book.note_offer(v);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic close_phase();
    item_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    capacity_we    <= 1'b1;
    capacity_wdata <= cap;
    @(posedge clk);
    capacity_we    <= 1'b0;
    book.set_capacity(cap);
  endtask

  // value mix: mostly wide random, some tight clusters and near-extremes;
  // repeats of held values and exact extremes only late, since they pin the
  // shortest span at zero for the rest of the run
  function automatic logic [VALUE_W-1:0] pick_value(bit dup_ok);
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, dup_ok ? 9 : 7))
      5: begin
        v = $urandom_range(0, 2000);
        v = v - 32'd1000;
      end
      6: v = 32'h8000_0000 + $urandom_range(1, 65535);
      7: v = 32'h7fff_ffff - $urandom_range(1, 65535);
      8: begin
        if (book.held.size() != 0) v = book.held[$urandom_range(0, book.held.size() - 1)];
        else v = $urandom;
      end
      9: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int         items_left;
    int         n;
    int         phase_no;
    int         held_now;
    bit         last_phase;
    bit         quiet;
    bit         dup_ok;
    logic [CAP_W-1:0] cap;

    book = new();
    rst            <= 1'b1;
    capacity_we    <= 1'b0;
    capacity_wdata <= '0;
    item_ch.valid  <= 1'b0;
    item_ch.value  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero capacity: every word refused, spans stay zero
    write_capacity(11'd0);
    send_word(32'h8000_0000);
    send_word(32'h7fff_ffff);
    send_word(32'h0000_0000);
    close_phase();

    // capacity of one: first word held with no spans yet, next refused
    write_capacity(11'd1);
    send_word(32'h8000_0000);
    send_word(32'h7fff_ffff);
    close_phase();

    // capacity above depth saturates; widest span first, then alternating bit patterns
    write_capacity(11'd2047);
    send_word(32'h7fff_ffff);
    send_word(32'h0000_0000);
    send_word(32'h5555_5555);
    send_word(32'haaaa_aaaa);
    send_word(32'hc000_0000);
    close_phase();

    // capacity equal to count, then below it: held values kept, new ones refused
    write_capacity(CAP_W'(book.held.size()));
    send_word(32'h1234_5678);
    close_phase();
    write_capacity(11'd3);
    send_word(32'hdead_beef);
    close_phase();
    write_capacity(CAP_RESET);

    // random phases, each behind its own capacity setting; the count only grows
    items_left = RANDOM_WORDS;
    phase_no   = 0;
    while (items_left > 0) begin
      last_phase = (items_left <= 60);
      n = last_phase ? items_left : $urandom_range(20, 50);
      if (n > items_left) n = items_left;
      held_now = book.held.size();
      if (last_phase) begin
        cap = 11'd2047;
      end else begin
        case ($urandom_range(0, 6))
          0: cap = '0;
          1: cap = CAP_W'(held_now);
          2: cap = (held_now > 5) ? CAP_W'(held_now - $urandom_range(1, 5)) : '0;
          3: cap = 11'd2047;
          4: cap = CAP_RESET;
          default: cap = CAP_W'(held_now + $urandom_range(1, 40));
        endcase
      end
      write_capacity(cap);

      // some phases run flat out; the tail never idles
      quiet = last_phase || ($urandom_range(0, 3) == 0);
      tx_idle_on = !quiet;
      rx_idle_on <= !quiet;
      if (phase_no == 1 || phase_no == 6) hold_asks <= hold_asks + 1;
      dup_ok = (items_left < 200);

      repeat (n) send_word(pick_value(dup_ok));
      close_phase();
      items_left -= n;
      phase_no++;
    end

    // let any stray result show up before the verdict
    repeat (SETTLE) @(posedge clk);
    book.report_leftover();
    if (book.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bsst_pkg.sv
design/bsst_item_if.sv
design/bsst_result_if.sv
design/bounded_set_span_tracker.sv
tb/span_book_pkg.sv
tb/tb_bounded_set_span_tracker.sv
